FILE: sv/assert_macros.svh
// assertion macros shared by the control surface to midi rtl
// no dependencies; the including module must have clock and reset signals
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CTSM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CTSM_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define CTSM_ASSERT(lbl, prop, msg)
`define CTSM_NEVER(lbl, expr, msg)
`endif
`endif

FILE: sv/ctsm_pkg.sv
// shared types, constants and helpers for the control surface to midi block
// no dependencies
package ctsm_pkg;

   localparam int CHANNELS  = 16;
   localparam int CH_W      = $clog2(CHANNELS);
   localparam int MAX_PADS  = 64;
   localparam int KIND_W    = 3;
   localparam int CSR_IDX_W = 3;

   localparam logic [KIND_W-1:0] KIND_BUTTON  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ENCODER = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SLIDER  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PAD     = 3'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_PADS_IN_GRID = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_VEL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_BTN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_BTN    = 3'd4;

   localparam logic [7:0] ST_CC         = 8'hB0;
   localparam logic [7:0] ST_ON         = 8'h90;
   localparam logic [7:0] ST_OFF        = 8'h80;
   localparam logic [7:0] BTN_NOTE_BASE = 8'd60;
   localparam logic [7:0] PAD_NOTE_BASE = 8'd24;
   localparam logic [6:0] VAL_MAX       = 7'd127;
   localparam logic [7:0] CC_SLIDER     = 8'd1;
   localparam logic [7:0] CC_ENCODER    = 8'd2;

   // one accepted event plus the state it sees
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [7:0]        id;
      logic              pressed;
      logic signed [7:0] delta;
      logic [15:0]       level;
      logic [CH_W-1:0]   ch;
      logic              shift;
      logic              vfix;
      logic [6:0]        group_sel;
      logic              emit;
   } evt_type;

   typedef struct packed {
      logic [6:0] data_second;
      logic [7:0] data_first;
      logic [7:0] status_byte;
   } msg_type;

   // q1.15 level times 127, truncated, saturated at 127
   function automatic logic [6:0] level_to_7bit(input logic [15:0] lvl);
      logic [22:0] prod;
      logic [7:0]  v;
      prod = {lvl, 7'b0} - {7'b0, lvl};
      v    = prod[22:15];
      return v[7] ? VAL_MAX : v[6:0];
   endfunction

endpackage

FILE: sv/ctsm_ram.sv
// generic single write port ram with registered read
// no dependencies
module ctsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/ctsm_enc.sv
// per-channel encoder value store: ram, valid bits and write bypass
// depends on ctsm_pkg and ctsm_ram
`include "assert_macros.svh"
module ctsm_enc
   import ctsm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            rd_en,
   input  logic [CH_W-1:0] rd_ch,
   input  logic            wr_en,
   input  logic [CH_W-1:0] wr_ch,
   input  logic [6:0]      wr_data,
   output logic [6:0]      rd_value
);

   logic [CHANNELS-1:0] vld_ff, vld_in;
   logic                byp_hit_ff;
   logic [6:0]          byp_data_ff;
   logic                rvld_ff;
   logic [6:0]          ram_rdata;

   ctsm_ram #(.WIDTH(7), .DEPTH(CHANNELS)) u_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_ch),
      .wdata (wr_data),
      .re    (rd_en),
      .raddr (rd_ch),
      .rdata (ram_rdata)
   );

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_ch] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // a write landing on the same edge as the read is caught here
   always_ff @(posedge clock) begin
      if (rd_en) begin
         byp_hit_ff  <= wr_en && (wr_ch == rd_ch);
         byp_data_ff <= wr_data;
         rvld_ff     <= vld_ff[rd_ch];
      end
   end

   assign rd_value = byp_hit_ff ? byp_data_ff : (rvld_ff ? ram_rdata : 7'd0);

   `CTSM_ASSERT(a_wr_sets_valid, wr_en |=> vld_ff[$past(wr_ch)], "written entry not valid")

endmodule

FILE: sv/ctsm_front.sv
// configuration registers, hold flags, selections and event decode
// depends on ctsm_pkg
`include "assert_macros.svh"
module ctsm_front
   import ctsm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [KIND_W-1:0]    kind,
   input  logic [7:0]           control_id,
   input  logic                 pressed,
   input  logic signed [7:0]    encoder_delta,
   input  logic [15:0]          level,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   output evt_type              evt,
   output logic [6:0]           pads_in_grid
);

   logic [6:0]      pads_ff, pads_in;
   logic [6:0]      glimit_ff, glimit_in;
   logic [7:0]      fvb_ff, fvb_in;
   logic [7:0]      sbtn_ff, sbtn_in;
   logic [7:0]      gbtn_ff, gbtn_in;
   logic            shift_held_ff, shift_held_in;
   logic            group_held_ff, group_held_in;
   logic [6:0]      group_sel_ff, group_sel_in;
   logic [CH_W-1:0] channel_sel_ff, channel_sel_in;
   logic            vfix_ff, vfix_in;
   logic [6:0]      top;
   logic [6:0]      pad_pos;
   logic            pad_ok;
   logic            emit;

   always_comb begin
      pads_in   = pads_ff;
      glimit_in = glimit_ff;
      fvb_in    = fvb_ff;
      sbtn_in   = sbtn_ff;
      gbtn_in   = gbtn_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PADS_IN_GRID: pads_in   = csr_wdata[6:0];
            CSR_GROUP_LIMIT:  glimit_in = csr_wdata[6:0];
            CSR_FIXED_VEL:    fvb_in    = csr_wdata;
            CSR_SHIFT_BTN:    sbtn_in   = csr_wdata;
            CSR_GROUP_BTN:    gbtn_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   assign top     = (glimit_ff == 7'd0) ? 7'd0 : glimit_ff - 7'd1;
   assign pad_pos = control_id[6:0];
   assign pad_ok  = control_id < 8'(MAX_PADS);

   always_comb begin
      shift_held_in  = shift_held_ff;
      group_held_in  = group_held_ff;
      group_sel_in   = group_sel_ff;
      channel_sel_in = channel_sel_ff;
      vfix_in        = vfix_ff;
      emit           = 1'b0;
      unique case (kind)
         KIND_BUTTON: begin
            if (shift_held_ff) begin
               if (control_id == fvb_ff) begin
                  if (pressed) begin
                     vfix_in = !vfix_ff;
                  end
               end else if (control_id == sbtn_ff) begin
                  shift_held_in = pressed;
               end
            end else if (control_id == gbtn_ff) begin
               group_held_in = pressed;
            end else if (control_id == sbtn_ff) begin
               shift_held_in = pressed;
            end else begin
               emit = 1'b1;
            end
         end
         KIND_ENCODER, KIND_SLIDER: emit = 1'b1;
         KIND_PAD: begin
            if (pad_ok) begin
               if (group_held_ff) begin
                  group_sel_in = (pad_pos > top) ? top : pad_pos;
               end else if (shift_held_ff) begin
                  channel_sel_in = (control_id > 8'd15) ? 4'd15 : control_id[CH_W-1:0];
               end else begin
                  emit = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pads_ff        <= 7'd16;
         glimit_ff      <= 7'd6;
         fvb_ff         <= 8'd0;
         sbtn_ff        <= 8'd1;
         gbtn_ff        <= 8'd2;
         shift_held_ff  <= 1'b0;
         group_held_ff  <= 1'b0;
         group_sel_ff   <= 7'd0;
         channel_sel_ff <= '0;
         vfix_ff        <= 1'b0;
      end else begin
         pads_ff   <= pads_in;
         glimit_ff <= glimit_in;
         fvb_ff    <= fvb_in;
         sbtn_ff   <= sbtn_in;
         gbtn_ff   <= gbtn_in;
         if (accept) begin
            shift_held_ff  <= shift_held_in;
            group_held_ff  <= group_held_in;
            group_sel_ff   <= group_sel_in;
            channel_sel_ff <= channel_sel_in;
            vfix_ff        <= vfix_in;
         end
      end
   end

   // the event carries the state as it stood before its own update
   always_comb begin
      evt.kind      = kind;
      evt.id        = control_id;
      evt.pressed   = pressed;
      evt.delta     = encoder_delta;
      evt.level     = level;
      evt.ch        = channel_sel_ff;
      evt.shift     = shift_held_ff;
      evt.vfix      = vfix_ff;
      evt.group_sel = group_sel_ff;
      evt.emit      = emit;
   end

   assign pads_in_grid = pads_ff;

   `CTSM_ASSERT(a_shift, !accept || kind != KIND_BUTTON |=> $stable(shift_held_ff), "shift moved")
   `CTSM_ASSERT(a_chan, !accept || kind != KIND_PAD |=> $stable(channel_sel_ff), "channel moved")

endmodule

FILE: sv/control_surface_to_midi.sv
// control surface to midi translator, top level with message stage and output register
// depends on ctsm_pkg, ctsm_front, ctsm_enc
//
// Takes one control event per cycle unless stalled and returns at most one 3-byte MIDI
// message per event, through stage s1 and then the output register. Hold flags and
// selections live in registers updated on the accept edge, configuration in registers
// written over the csr port; the sixteen per-channel encoder values live in a small
// ram that is read on accept and written back as the event leaves s1, with a bypass
// when back-to-back encoder events hit the same channel. Events that make no message
// still take one slot in the pipeline. The input stalls only while a message waits
// in the output register and a new message stands behind it.
`include "assert_macros.svh"
module control_surface_to_midi
   import ctsm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [39:0]          req_tdata,  // control_id[7:0], pressed[8],
                                            // encoder_delta[16:9], level[32:17], zero
   input  logic [KIND_W-1:0]    req_tuser,  // kind
   input  logic                 req_tlast,  // batch_end
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,  // status_byte[7:0], data_first[15:8],
                                            // data_second[22:16], zero
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   logic            accept;
   evt_type         evt;
   logic [6:0]      pads_in_grid;
   evt_type         s1_ff;
   logic            s1_valid_ff, s1_valid_in;
   logic            s1_adv;
   logic [6:0]      enc_old;
   logic [6:0]      enc_new;
   logic signed [10:0] step, sum;
   logic [6:0]      lvl7;
   logic [13:0]     grp_off;
   logic [7:0]      note;
   logic            wr_en;
   logic            rsp_load;
   msg_type         msg;
   msg_type         rsp_ff;
   logic            rsp_valid_ff, rsp_valid_in;

   assign accept     = req_tvalid && req_tready;
   assign s1_adv     = !s1_ff.emit || !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;

   ctsm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .kind          (req_tuser),
      .control_id    (req_tdata[7:0]),
      .pressed       (req_tdata[8]),
      .encoder_delta (req_tdata[16:9]),
      .level         (req_tdata[32:17]),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .evt           (evt),
      .pads_in_grid  (pads_in_grid)
   );

   assign wr_en = s1_valid_ff && s1_adv && (s1_ff.kind == KIND_ENCODER);

   ctsm_enc u_enc (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_ch    (evt.ch),
      .wr_en    (wr_en),
      .wr_ch    (s1_ff.ch),
      .wr_data  (enc_new),
      .rd_value (enc_old)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= evt;
      end
   end

   // encoder step, x4 under shift, saturating at 0 and 127
   always_comb begin
      step = s1_ff.shift ? {s1_ff.delta[7], s1_ff.delta, 2'b00}
                         : {{3{s1_ff.delta[7]}}, s1_ff.delta};
      sum  = $signed({4'b0000, enc_old}) + step;
      if (sum[10]) begin
         enc_new = 7'd0;
      end else if (sum > 11'sd127) begin
         enc_new = VAL_MAX;
      end else begin
         enc_new = sum[6:0];
      end
   end

   assign lvl7    = level_to_7bit(s1_ff.level);
   assign grp_off = s1_ff.group_sel * pads_in_grid;
   assign note    = PAD_NOTE_BASE + grp_off[7:0] + s1_ff.id;

   always_comb begin
      msg.status_byte = {ST_CC[7:4], s1_ff.ch};
      msg.data_first  = BTN_NOTE_BASE + s1_ff.id;
      msg.data_second = s1_ff.pressed ? VAL_MAX : 7'd0;
      unique case (s1_ff.kind)
         KIND_ENCODER: begin
            msg.data_first  = CC_ENCODER;
            msg.data_second = enc_new;
         end
         KIND_SLIDER: begin
            msg.data_first  = CC_SLIDER;
            msg.data_second = lvl7;
         end
         KIND_PAD: begin
            msg.status_byte = s1_ff.pressed ? {ST_ON[7:4], s1_ff.ch} : {ST_OFF[7:4], s1_ff.ch};
            msg.data_first  = note;
            if (!s1_ff.pressed) begin
               msg.data_second = 7'd0;
            end else if (s1_ff.vfix) begin
               msg.data_second = VAL_MAX;
            end else begin
               msg.data_second = lvl7;
            end
         end
         default: ;
      endcase
   end

   assign rsp_load = s1_valid_ff && s1_ff.emit && s1_adv;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= msg;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

   `CTSM_ASSERT(a_accept_fills_s1, accept |=> s1_valid_ff, "accepted word lost")
   `CTSM_NEVER(a_no_overwrite, rsp_load && rsp_valid_ff && !rsp_tready, "waiting word lost")

endmodule
